/* hdl/assert_macros.svh */
// assertion helpers shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, ignored while reset is applied
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// clocked assertion that is also checked during reset
`define ASSERT_CLK(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/sidft_pkg.sv */
package sidft_pkg;

	// fixed field widths
	localparam int ID_W     = 29;
	localparam int ACT_W    = 2;
	localparam int RIDX_W   = 6;
	localparam int STATUS_W = 3;
	localparam int POS_W    = 6;
	localparam int CNT_W    = 6;

	// action codes
	localparam logic [ACT_W-1:0] ACT_ADD   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd1;
	localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] STAT_ADDED   = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_PRESENT = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_CLEARED = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_READ    = 3'd4;
	localparam logic [STATUS_W-1:0] STAT_INVALID = 3'd7;

	// sequencer states, one-hot
	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_SRCH   = 7'b0000010,
		S_CMP    = 7'b0000100,
		S_SHIFT  = 7'b0001000,
		S_PUT    = 7'b0010000,
		S_RDWAIT = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

endpackage

/* hdl/sidft_mem.sv */
module sidft_mem #(
	parameter int DEPTH = 48,
	parameter int AW    = 6
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [AW-1:0]              wr_addr,
	input  logic [sidft_pkg::ID_W-1:0] wr_data,
	input  logic [AW-1:0]              rd_addr,
	output logic [sidft_pkg::ID_W-1:0] rd_data
);

	logic [sidft_pkg::ID_W-1:0] mem_q [DEPTH];
	logic [sidft_pkg::ID_W-1:0] rd_data_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

/* hdl/sorted_id_filter_table.sv */
// Sorted identifier filter table.
// Input channel (in_valid / in_stall) carries action, can_id and read_index;
// output channel (out_valid / out_stall) returns status, position,
// entry_value and entry_count, one transaction per input transaction.
// Identifiers are kept sorted in a single-port-write, registered-read RAM.
// One 29-bit compare unit is reused by a small sequencer: each binary search
// step is a RAM read state and a compare state, and inserting shifts one entry
// per cycle through the RAM write port.
// in_stall stays high after an accept until the result enters the output register.
// A finished result sits in the output register; while out_stall is high it
// holds, the block still takes one new transaction and parks its result
// until the register is free.
// Reset empties the table at once: entries past the count read back as one
// fill value (zero after reset or clear, the identifier of the latest add, new or held,
// after an add), so no clearing pass is needed.
module sorted_id_filter_table #(
	parameter int TABLE_DEPTH = 48
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [sidft_pkg::ACT_W-1:0]    action,
	input  logic [sidft_pkg::ID_W-1:0]     can_id,
	input  logic [sidft_pkg::RIDX_W-1:0]   read_index,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [sidft_pkg::STATUS_W-1:0] status,
	output logic [sidft_pkg::POS_W-1:0]    position,
	output logic [sidft_pkg::ID_W-1:0]     entry_value,
	output logic [sidft_pkg::CNT_W-1:0]    entry_count
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int XW = (CW > sidft_pkg::RIDX_W) ? CW : sidft_pkg::RIDX_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
	localparam logic [XW-1:0] DEPTH_X = XW'(TABLE_DEPTH);

	sidft_pkg::state_t state_q;

	logic [CW-1:0]                  count_q;
	logic [sidft_pkg::ID_W-1:0]     fill_q;
	logic [sidft_pkg::ID_W-1:0]     key_q;
	logic [CW-1:0]                  lo_q;
	logic [CW-1:0]                  hi_q;
	logic [AW-1:0]                  mid_q;
	logic [AW-1:0]                  sh_q;
	logic [AW-1:0]                  wa_q;
	logic                           wr_pend_q;
	logic                           rd_go_q;
	logic                           rd_mem_q;
	logic                           rd_fill_q;
	logic [sidft_pkg::STATUS_W-1:0] res_status_q;
	logic [sidft_pkg::POS_W-1:0]    res_pos_q;
	logic [sidft_pkg::ID_W-1:0]     res_val_q;
	logic                           out_valid_q;
	logic [sidft_pkg::STATUS_W-1:0] status_q;
	logic [sidft_pkg::POS_W-1:0]    position_q;
	logic [sidft_pkg::ID_W-1:0]     entry_value_q;
	logic [sidft_pkg::CNT_W-1:0]    entry_count_q;

	logic                       accept;
	logic                       out_load;
	logic [CW-1:0]              mid_c;
	logic                       key_eq;
	logic                       key_lt;
	logic [XW-1:0]              ridx_x;
	logic [XW-1:0]              count_x;
	logic                       mem_wr_en;
	logic [AW-1:0]              mem_wr_addr;
	logic [sidft_pkg::ID_W-1:0] mem_wr_data;
	logic [AW-1:0]              mem_rd_addr;
	logic [sidft_pkg::ID_W-1:0] mem_rd_data;

	assign in_stall = (state_q != sidft_pkg::S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_load = (state_q == sidft_pkg::S_DONE) && (!out_valid_q || !out_stall);

	// midpoint of the search window
	assign mid_c = lo_q + ((hi_q - lo_q) >> 1);

	// shared compare unit
	assign key_eq = (mem_rd_data == key_q);
	assign key_lt = (mem_rd_data < key_q);

	assign ridx_x  = XW'(read_index);
	assign count_x = XW'(count_q);

	// ram port selection
	always_comb begin
		mem_wr_en   = 1'b0;
		mem_wr_addr = wa_q;
		mem_wr_data = mem_rd_data;
		mem_rd_addr = sh_q;
		unique case (state_q)
			sidft_pkg::S_IDLE: begin
				mem_rd_addr = AW'(read_index);
			end
			sidft_pkg::S_SRCH: begin
				mem_rd_addr = AW'(mid_c);
			end
			sidft_pkg::S_SHIFT: begin
				mem_wr_en = wr_pend_q;
			end
			sidft_pkg::S_PUT: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = AW'(lo_q);
				mem_wr_data = key_q;
			end
			default: begin
			end
		endcase
	end

	sidft_mem #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	// sequencer and table control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sidft_pkg::S_IDLE;
			count_q   <= '0;
			fill_q    <= '0;
			wr_pend_q <= 1'b0;
			rd_go_q   <= 1'b0;
		end else begin
			unique case (state_q)
				sidft_pkg::S_IDLE: begin
					if (accept) begin
						priority case (action)
							sidft_pkg::ACT_ADD:   state_q <= sidft_pkg::S_SRCH;
							sidft_pkg::ACT_CLEAR: begin
								count_q <= '0;
								fill_q  <= '0;
								state_q <= sidft_pkg::S_DONE;
							end
							sidft_pkg::ACT_READ:  state_q <= sidft_pkg::S_RDWAIT;
							default:              state_q <= sidft_pkg::S_DONE;
						endcase
					end
				end
				sidft_pkg::S_SRCH: begin
					if (lo_q < hi_q) begin
						state_q <= sidft_pkg::S_CMP;
					end else if (count_q < DEPTH_C) begin
						if (count_q == lo_q) begin
							state_q <= sidft_pkg::S_PUT;
						end else begin
							rd_go_q   <= 1'b1;
							wr_pend_q <= 1'b0;
							state_q   <= sidft_pkg::S_SHIFT;
						end
					end else begin
						state_q <= sidft_pkg::S_DONE;
					end
				end
				sidft_pkg::S_CMP: begin
					if (key_eq) begin
						fill_q  <= key_q;
						state_q <= sidft_pkg::S_DONE;
					end else begin
						state_q <= sidft_pkg::S_SRCH;
					end
				end
				sidft_pkg::S_SHIFT: begin
					// read one entry per cycle, write it one slot up in the following cycle
					if (rd_go_q) begin
						wr_pend_q <= 1'b1;
						if (CW'(sh_q) == lo_q) begin
							rd_go_q <= 1'b0;
						end
					end else begin
						wr_pend_q <= 1'b0;
						state_q   <= sidft_pkg::S_PUT;
					end
				end
				sidft_pkg::S_PUT: begin
					count_q <= count_q + 1'b1;
					fill_q  <= key_q;
					state_q <= sidft_pkg::S_DONE;
				end
				sidft_pkg::S_RDWAIT: begin
					state_q <= sidft_pkg::S_DONE;
				end
				sidft_pkg::S_DONE: begin
					if (out_load) begin
						state_q <= sidft_pkg::S_IDLE;
					end
				end
				default: state_q <= sidft_pkg::S_IDLE;
			endcase
		end
	end

	// search window, shift pointers and result fields
	always_ff @(posedge clk) begin
		unique case (state_q)
			sidft_pkg::S_IDLE: begin
				key_q     <= can_id;
				lo_q      <= '0;
				hi_q      <= count_q;
				rd_mem_q  <= (ridx_x < count_x);
				rd_fill_q <= (ridx_x < DEPTH_X);
				res_pos_q <= '0;
				res_val_q <= '0;
				priority case (action)
					sidft_pkg::ACT_ADD:   res_status_q <= sidft_pkg::STAT_ADDED;
					sidft_pkg::ACT_CLEAR: res_status_q <= sidft_pkg::STAT_CLEARED;
					sidft_pkg::ACT_READ:  res_status_q <= sidft_pkg::STAT_READ;
					default:              res_status_q <= sidft_pkg::STAT_INVALID;
				endcase
			end
			sidft_pkg::S_SRCH: begin
				mid_q <= AW'(mid_c);
				sh_q  <= AW'(count_q - 1'b1);
				if (!(lo_q < hi_q) && !(count_q < DEPTH_C)) begin
					res_status_q <= sidft_pkg::STAT_FULL;
				end
			end
			sidft_pkg::S_CMP: begin
				if (key_eq) begin
					res_status_q <= sidft_pkg::STAT_PRESENT;
					res_pos_q    <= sidft_pkg::POS_W'(mid_q);
				end else if (key_lt) begin
					lo_q <= CW'(mid_q) + 1'b1;
				end else begin
					hi_q <= CW'(mid_q);
				end
			end
			sidft_pkg::S_SHIFT: begin
				if (rd_go_q) begin
					wa_q <= sh_q + 1'b1;
					if (CW'(sh_q) != lo_q) begin
						sh_q <= sh_q - 1'b1;
					end
				end
			end
			sidft_pkg::S_PUT: begin
				res_status_q <= sidft_pkg::STAT_ADDED;
				res_pos_q    <= sidft_pkg::POS_W'(lo_q);
			end
			sidft_pkg::S_RDWAIT: begin
				if (rd_mem_q) begin
					res_val_q <= mem_rd_data;
				end else if (rd_fill_q) begin
					res_val_q <= fill_q;
				end else begin
					res_val_q <= '0;
				end
			end
			default: begin
			end
		endcase
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q      <= res_status_q;
			position_q    <= res_pos_q;
			entry_value_q <= res_val_q;
			entry_count_q <= sidft_pkg::CNT_W'(count_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign position    = position_q;
	assign entry_value = entry_value_q;
	assign entry_count = entry_count_q;

endmodule

/* hdl/sidft_checker.sv */
`include "assert_macros.svh"

module sidft_checker #(
	parameter int TABLE_DEPTH = 48
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [sidft_pkg::STATUS_W-1:0] status,
	input logic [sidft_pkg::POS_W-1:0]    position,
	input logic [sidft_pkg::ID_W-1:0]     entry_value,
	input logic [sidft_pkg::CNT_W-1:0]    entry_count
);

	// block takes one transaction at a time
	`ASSERT_CLK_RST(a_busy_after_accept, clk, arst_n,
		(in_valid && !in_stall) |=> in_stall,
		"input taken while a transaction is in progress")

	// count never exceeds the table size
	`ASSERT_CLK_RST(a_count_range, clk, arst_n,
		out_valid |-> ((TABLE_DEPTH >= 64) || (entry_count <= TABLE_DEPTH)),
		"entry count beyond table depth")

	// an add reports a slot inside the occupied prefix
	`ASSERT_CLK_RST(a_pos_in_prefix, clk, arst_n,
		(out_valid && ((status == sidft_pkg::STAT_ADDED) ||
			(status == sidft_pkg::STAT_PRESENT)))
		|-> ((TABLE_DEPTH >= 64) || (position < entry_count)),
		"position outside occupied entries")

	// a clear empties the table
	`ASSERT_CLK_RST(a_clear_empty, clk, arst_n,
		(out_valid && (status == sidft_pkg::STAT_CLEARED))
		|-> ((entry_count == '0) && (position == '0) && (entry_value == '0)),
		"clear result not empty")

	// stalled result holds
	`ASSERT_CLK_RST(a_out_hold, clk, arst_n,
		(out_valid && out_stall) |=> (out_valid && $stable(status) &&
			$stable(position) && $stable(entry_value) && $stable(entry_count)),
		"stalled result changed")

endmodule

bind sorted_id_filter_table sidft_checker #(
	.TABLE_DEPTH (TABLE_DEPTH)
) u_sidft_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.status      (status),
	.position    (position),
	.entry_value (entry_value),
	.entry_count (entry_count)
);

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;

	localparam int TABLE_DEPTH = 48;
	localparam int SETTLE_CYCLES = 80;
	// the two-bit action field has one code with no function
	localparam logic [sidft_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;
	localparam logic [sidft_pkg::ID_W-1:0] ID_MAX = {sidft_pkg::ID_W{1'b1}};

	typedef struct packed {
		logic [sidft_pkg::STATUS_W-1:0] status;
		logic [sidft_pkg::POS_W-1:0]    position;
		logic [sidft_pkg::ID_W-1:0]     entry_value;
		logic [sidft_pkg::CNT_W-1:0]    entry_count;
	} filter_result_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic [sidft_pkg::ACT_W-1:0]    action = sidft_pkg::ACT_ADD;
	logic [sidft_pkg::ID_W-1:0]     can_id = '0;
	logic [sidft_pkg::RIDX_W-1:0]   read_index = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic [sidft_pkg::STATUS_W-1:0] status;
	logic [sidft_pkg::POS_W-1:0]    position;
	logic [sidft_pkg::ID_W-1:0]     entry_value;
	logic [sidft_pkg::CNT_W-1:0]    entry_count;

	// shadow copy of the filter table
	logic [sidft_pkg::ID_W-1:0] shadow_ids [TABLE_DEPTH];
	int                         shadow_count;

	filter_result_t pending_results [$];
	bit             no_idle = 1'b0;
	int             fail_count = 0;
	int             items_sent = 0;
	int             results_checked = 0;
	int             full_rejects = 0;
	int             present_hits = 0;

	sorted_id_filter_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.can_id(can_id),
		.read_index(read_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.position(position),
		.entry_value(entry_value),
		.entry_count(entry_count)
	);

	// clock
	initial begin
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin
		#(20_000_000);
		$display("Verification failed");
		$finish;
	end

	// random identifier and random index
	function automatic logic [sidft_pkg::ID_W-1:0] rand_id();
		return sidft_pkg::ID_W'($urandom);
	endfunction

	function automatic logic [sidft_pkg::RIDX_W-1:0] rand_idx();
		return sidft_pkg::RIDX_W'($urandom);
	endfunction

	// apply one transaction to the shadow table and return the expected result
	function automatic filter_result_t apply_filter_op(
			input logic [sidft_pkg::ACT_W-1:0] act,
			input logic [sidft_pkg::ID_W-1:0] id,
			input logic [sidft_pkg::RIDX_W-1:0] idx);
		filter_result_t r;
		int lo;
		int hi;
		int mid;
		int slot;
		bit found;
		r = '0;
		r.status = sidft_pkg::STAT_INVALID;
		case (act)
			sidft_pkg::ACT_ADD: begin
				lo = 0;
				hi = shadow_count;
				found = 1'b0;
				slot = 0;
				// binary search over the sorted prefix
				while (lo < hi && !found) begin
					mid = lo + (hi - lo) / 2;
					if (shadow_ids[mid] == id) begin
						found = 1'b1;
						slot = mid;
					end else if (shadow_ids[mid] < id) begin
						lo = mid + 1;
					end else begin
						hi = mid;
					end
				end
				if (found) begin
					r.status = sidft_pkg::STAT_PRESENT;
					r.position = slot[sidft_pkg::POS_W-1:0];
					present_hits++;
				end else if (shadow_count < TABLE_DEPTH) begin
					slot = lo;
					for (int i = shadow_count; i > slot; i--)
						shadow_ids[i] = shadow_ids[i-1];
					shadow_ids[slot] = id;
					shadow_count++;
					r.status = sidft_pkg::STAT_ADDED;
					r.position = slot[sidft_pkg::POS_W-1:0];
				end else begin
					r.status = sidft_pkg::STAT_FULL;
					full_rejects++;
				end
				// unused slots take the identifier of the last add
				for (int i = shadow_count; i < TABLE_DEPTH; i++)
					shadow_ids[i] = id;
			end
			sidft_pkg::ACT_CLEAR: begin
				for (int i = 0; i < TABLE_DEPTH; i++)
					shadow_ids[i] = '0;
				shadow_count = 0;
				r.status = sidft_pkg::STAT_CLEARED;
			end
			sidft_pkg::ACT_READ: begin
				r.status = sidft_pkg::STAT_READ;
				if (idx < TABLE_DEPTH)
					r.entry_value = shadow_ids[idx];
			end
			default: begin
			end
		endcase
		r.entry_count = shadow_count[sidft_pkg::CNT_W-1:0];
		return r;
	endfunction

	// send one transaction, predict its result once accepted
	task automatic send_item(input logic [sidft_pkg::ACT_W-1:0] act,
			input logic [sidft_pkg::ID_W-1:0] id,
			input logic [sidft_pkg::RIDX_W-1:0] idx);
		if (!no_idle && $urandom_range(99) < 25) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		action     <= act;
		can_id     <= id;
		read_index <= idx;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_results.push_back(apply_filter_op(act, id, idx));
		items_sent++;
	endtask

	// pick an identifier: often one already held, sometimes a small one
	function automatic logic [sidft_pkg::ID_W-1:0] pick_id();
		if (shadow_count > 0 && $urandom_range(2) == 0)
			return shadow_ids[$urandom_range(shadow_count - 1)];
		if ($urandom_range(3) == 0)
			return sidft_pkg::ID_W'($urandom_range(63));
		return rand_id();
	endfunction

	// result side stalls at random
	always @(posedge clk) begin
		out_stall <= !no_idle && ($urandom_range(99) < 25);
	end

	// compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		filter_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result transaction with no prediction pending");
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, status);
					fail_count++;
				end
				if (position !== want.position) begin
					$error("position: expected %0d, actual %0d", want.position, position);
					fail_count++;
				end
				if (entry_value !== want.entry_value) begin
					$error("entry_value: expected 0x%0h, actual 0x%0h",
						want.entry_value, entry_value);
					fail_count++;
				end
				if (entry_count !== want.entry_count) begin
					$error("entry_count: expected %0d, actual %0d",
						want.entry_count, entry_count);
					fail_count++;
				end
			end
		end
	end

	// extremes, duplicates, fill values, bad index, unused action, clear
	task automatic test_directed_cases();
		send_item(sidft_pkg::ACT_READ, ID_MAX, 6'd0);
		send_item(sidft_pkg::ACT_READ, '0, 6'd63);
		send_item(sidft_pkg::ACT_ADD, '0, 6'd0);
		send_item(sidft_pkg::ACT_ADD, ID_MAX, 6'd63);
		send_item(sidft_pkg::ACT_ADD, '0, 6'd0);
		send_item(sidft_pkg::ACT_READ, '0, 6'd47);
		send_item(sidft_pkg::ACT_ADD, 29'h0AAAAAAA, 6'd0);
		send_item(sidft_pkg::ACT_ADD, 29'h15555555, 6'd0);
		send_item(sidft_pkg::ACT_ADD, 29'h00000001, 6'd0);
		send_item(sidft_pkg::ACT_READ, '0, 6'd1);
		send_item(sidft_pkg::ACT_READ, '0, 6'd4);
		send_item(sidft_pkg::ACT_READ, '0, 6'd47);
		send_item(sidft_pkg::ACT_ADD, ID_MAX, 6'd0);
		send_item(sidft_pkg::ACT_READ, '0, 6'd47);
		send_item(sidft_pkg::ACT_READ, '0, 6'd48);
		send_item(ACT_UNUSED, ID_MAX, 6'd5);
		send_item(ACT_UNUSED, '0, 6'd63);
		send_item(sidft_pkg::ACT_CLEAR, ID_MAX, 6'd63);
		send_item(sidft_pkg::ACT_READ, '0, 6'd0);
		send_item(sidft_pkg::ACT_READ, '0, 6'd47);
		send_item(sidft_pkg::ACT_ADD, 29'h10000000, 6'd0);
	endtask

	// fill the table to its depth, then hit the full rejection
	task automatic test_fill_to_full();
		logic [sidft_pkg::ID_W-1:0] id;
		send_item(sidft_pkg::ACT_CLEAR, rand_id(), rand_idx());
		// descending run forces long shifts to the front
		id = 29'h1F000000;
		while (shadow_count < TABLE_DEPTH / 2) begin
			send_item(sidft_pkg::ACT_ADD, id, rand_idx());
			id = id - sidft_pkg::ID_W'($urandom_range(1, 4096));
		end
		while (shadow_count < TABLE_DEPTH)
			send_item(sidft_pkg::ACT_ADD, rand_id(), rand_idx());
		send_item(sidft_pkg::ACT_ADD, ID_MAX, rand_idx());
		send_item(sidft_pkg::ACT_ADD, '0, rand_idx());
		for (int i = 0; i < 4; i++)
			send_item(sidft_pkg::ACT_ADD, rand_id(), rand_idx());
		for (int i = 0; i < 4; i++)
			send_item(sidft_pkg::ACT_ADD, shadow_ids[$urandom_range(TABLE_DEPTH - 1)],
				rand_idx());
		send_item(sidft_pkg::ACT_READ, rand_id(), 6'd0);
		send_item(sidft_pkg::ACT_READ, rand_id(), 6'd47);
		send_item(sidft_pkg::ACT_READ, rand_id(), 6'd48);
		send_item(sidft_pkg::ACT_READ, rand_id(), 6'd63);
	endtask

	// random mix of adds, reads, rare clears and unused actions
	task automatic test_random_traffic(input int count);
		int pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 1)
				send_item(sidft_pkg::ACT_CLEAR, rand_id(), rand_idx());
			else if (pick < 5)
				send_item(ACT_UNUSED, rand_id(), rand_idx());
			else if (pick < 60)
				send_item(sidft_pkg::ACT_ADD, pick_id(), rand_idx());
			else if ($urandom_range(4) == 0)
				send_item(sidft_pkg::ACT_READ, rand_id(),
					sidft_pkg::RIDX_W'($urandom_range(TABLE_DEPTH, 63)));
			else
				send_item(sidft_pkg::ACT_READ, rand_id(),
					sidft_pkg::RIDX_W'($urandom_range(TABLE_DEPTH - 1)));
		end
	endtask

	// long stretch with neither side idling
	task automatic test_back_to_back();
		no_idle = 1'b1;
		test_random_traffic(70);
		no_idle = 1'b0;
	endtask

	// main sequence
	initial begin
		for (int i = 0; i < TABLE_DEPTH; i++)
			shadow_ids[i] = '0;
		shadow_count = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_fill_to_full();
		test_random_traffic(150);
		test_back_to_back();
		test_random_traffic(100);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("sent %0d transactions, checked %0d results", items_sent, results_checked);
		$display("duplicate adds %0d, full-table rejections %0d", present_hits, full_rejects);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
